// ===== hw/rtl/address_hotspot_profile_table_unit_macros.svh =====
// Assertion macros for the address hotspot profile table.
// Used by the checker; no other dependencies.
`ifndef ADDRESS_HOTSPOT_PROFILE_TABLE_UNIT_MACROS_SVH
`define ADDRESS_HOTSPOT_PROFILE_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define AHPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ahpt assertion failed");

// next-cycle implication
`define AHPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ahpt assertion failed");

`endif

// ===== hw/rtl/ahpt_pkg.sv =====
// Shared constants, types and control structs of the address hotspot profile table.
// No dependencies.
package ahpt_pkg;

    localparam int TABLE_SLOTS   = 256;
    localparam int OUTCOME_KINDS = 8;
    localparam int SLOT_BITS     = $clog2(TABLE_SLOTS);
    localparam int OC_BITS       = (OUTCOME_KINDS > 1) ? $clog2(OUTCOME_KINDS) : 1;

    localparam logic [31:0] HASH_MULT = 32'd2654435761;
    localparam logic [7:0]  OC_LIMIT  = 8'(OUTCOME_KINDS);

    localparam int APB_ADDR_W = 3;
    localparam logic [0:0] REG_OUTCOME_FALLBACK = 1'b0;

    typedef enum logic [1:0] {
        STATUS_HIT      = 2'd0,
        STATUS_NEW      = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [31:0] address;
        logic [31:0] samples;
        logic [63:0] cycle_sum;
        logic [31:0] cycle_max;
    } t_slot_row;

    typedef struct packed {
        logic [31:0] samples;
        logic [63:0] cycles;
    } t_lane;

    typedef struct packed {
        logic                 rd_en;
        logic [SLOT_BITS-1:0] rd_idx;
        logic [OC_BITS-1:0]   rd_oc;
        logic                 wr_en;
        logic                 wr_new;
        logic [SLOT_BITS-1:0] wr_idx;
        logic [OC_BITS-1:0]   wr_oc;
        t_slot_row            wr_row;
        t_lane                wr_lane;
    } t_store_req;

    typedef struct packed {
        logic      valid;
        t_slot_row row;
        t_lane     lane;
    } t_store_rsp;

    typedef struct packed {
        logic               sample;
        logic [31:0]        cycles;
        logic [OC_BITS-1:0] oc;
        logic               insert;
        logic               overflow;
    } t_tot_upd;

    typedef struct packed {
        logic [31:0] samples;
        logic [63:0] cycle_sum;
        logic [31:0] cycle_max;
        logic [8:0]  occupied;
        logic [31:0] overflow;
    } t_totals;

endpackage

// ===== hw/rtl/ahpt_ifs.sv =====
// Sample and result channel interfaces (valid/ready with payload).
// No dependencies.
interface ahpt_sample_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample_address;
    logic [31:0] sample_cycles;
    logic [7:0]  outcome_code;

    modport source (output valid, sample_address, sample_cycles, outcome_code,
                    input ready);
    modport sink (input valid, sample_address, sample_cycles, outcome_code,
                  output ready);
endinterface

interface ahpt_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  slot_index;
    logic [31:0] entry_samples;
    logic [63:0] entry_cycle_sum;
    logic [31:0] entry_cycle_max;
    logic [31:0] entry_outcome_samples;
    logic [63:0] entry_outcome_cycles;
    logic [31:0] global_samples;
    logic [63:0] global_cycle_sum;
    logic [31:0] global_cycle_max;
    logic [8:0]  distinct_addresses;
    logic [31:0] overflow_samples;

    modport source (output valid, status, slot_index, entry_samples, entry_cycle_sum,
                    entry_cycle_max, entry_outcome_samples, entry_outcome_cycles,
                    global_samples, global_cycle_sum, global_cycle_max,
                    distinct_addresses, overflow_samples,
                    input ready);
    modport sink (input valid, status, slot_index, entry_samples, entry_cycle_sum,
                  entry_cycle_max, entry_outcome_samples, entry_outcome_cycles,
                  global_samples, global_cycle_sum, global_cycle_max,
                  distinct_addresses, overflow_samples,
                  output ready);
endinterface

// ===== hw/rtl/ahpt_cfg_apb.sv =====
// APB register block: outcome fallback register.
// Depends on ahpt_pkg.
module ahpt_cfg_apb
    import ahpt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output logic [2:0]            o_fallback
);

    logic [2:0] r_fallback;
    logic [0:0] w_reg_idx;
    logic       w_wr;

    assign w_reg_idx  = paddr[APB_ADDR_W-1:2];
    assign w_wr       = psel && penable && pwrite;
    assign pready     = 1'b1;
    assign o_fallback = r_fallback;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fallback <= 3'd0;
        end else if (w_wr && (w_reg_idx == REG_OUTCOME_FALLBACK)) begin
            r_fallback <= pwdata[2:0];
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_OUTCOME_FALLBACK: prdata = {29'd0, r_fallback};
            default:              prdata = 32'd0;
        endcase
    end

endmodule

// ===== hw/rtl/ahpt_totals.sv =====
// Global totals: sample count, cycle sum and max, per-outcome tallies,
// occupancy and overflow counters. Depends on ahpt_pkg.
module ahpt_totals
    import ahpt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_tot_upd i_upd,
    output t_totals  o_tot
);

    t_totals     r_tot;
    logic [31:0] r_oc_samples [OUTCOME_KINDS];
    logic [63:0] r_oc_cycles  [OUTCOME_KINDS];

    assign o_tot = r_tot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tot <= '0;
            for (int k = 0; k < OUTCOME_KINDS; k++) begin
                r_oc_samples[k] <= 32'd0;
                r_oc_cycles[k]  <= 64'd0;
            end
        end else begin
            if (i_upd.sample) begin
                r_tot.samples   <= r_tot.samples + 32'd1;
                r_tot.cycle_sum <= r_tot.cycle_sum + {32'd0, i_upd.cycles};
                if (i_upd.cycles > r_tot.cycle_max) begin
                    r_tot.cycle_max <= i_upd.cycles;
                end
                r_oc_samples[i_upd.oc] <= r_oc_samples[i_upd.oc] + 32'd1;
                r_oc_cycles[i_upd.oc]  <= r_oc_cycles[i_upd.oc] + {32'd0, i_upd.cycles};
            end
            if (i_upd.insert) begin
                r_tot.occupied <= r_tot.occupied + 9'd1;
            end
            if (i_upd.overflow) begin
                r_tot.overflow <= r_tot.overflow + 32'd1;
            end
        end
    end

endmodule

// ===== hw/rtl/ahpt_slot_store.sv =====
// Slot table storage: valid bits, slot row memory and per-outcome lane memory.
// Synchronous read: data is available in the cycle after rd_en. Depends on ahpt_pkg.
module ahpt_slot_store
    import ahpt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_store_req i_req,
    output t_store_rsp o_rsp
);

    logic [TABLE_SLOTS-1:0] r_valid;
    t_slot_row              r_slot_mem [TABLE_SLOTS];
    t_lane                  r_lane_mem [TABLE_SLOTS][OUTCOME_KINDS];

    logic                   r_rd_valid;
    logic [OC_BITS-1:0]     r_rd_oc;
    t_slot_row              r_rd_row;
    t_lane                  r_rd_lanes [OUTCOME_KINDS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_req.wr_en && i_req.wr_new) begin
            r_valid[i_req.wr_idx] <= 1'b1;
        end
    end

    // new entries zero the lanes of the other outcomes
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_slot_mem[i_req.wr_idx] <= i_req.wr_row;
            for (int k = 0; k < OUTCOME_KINDS; k++) begin
                if (OC_BITS'(k) == i_req.wr_oc) begin
                    r_lane_mem[i_req.wr_idx][k] <= i_req.wr_lane;
                end else if (i_req.wr_new) begin
                    r_lane_mem[i_req.wr_idx][k] <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_valid <= r_valid[i_req.rd_idx];
            r_rd_oc    <= i_req.rd_oc;
            r_rd_row   <= r_slot_mem[i_req.rd_idx];
            r_rd_lanes <= r_lane_mem[i_req.rd_idx];
        end
    end

    always_comb begin
        o_rsp.valid       = r_rd_valid;
        o_rsp.row.address = r_rd_row.address;
        if (r_rd_valid) begin
            o_rsp.row.samples   = r_rd_row.samples;
            o_rsp.row.cycle_sum = r_rd_row.cycle_sum;
            o_rsp.row.cycle_max = r_rd_row.cycle_max;
            o_rsp.lane          = r_rd_lanes[r_rd_oc];
        end else begin
            o_rsp.row.samples   = 32'd0;
            o_rsp.row.cycle_sum = 64'd0;
            o_rsp.row.cycle_max = 32'd0;
            o_rsp.lane          = '0;
        end
    end

endmodule

// ===== hw/rtl/address_hotspot_profile_table_unit.sv =====
// Each sample is handled in turn: a probe reads the slot memory (ST_READ), then
// compares it (ST_CHECK), stepping to the next slot on a mismatch, and the
// result is loaded into the output register in ST_OUT. No new sample is taken
// until the unit is back in ST_IDLE; a full-table overflow walks all 256 slots.
// Reset (sync, active low) clears valid bits, totals, config and handshakes;
// memory contents are masked by the valid bits, so no clearing pass is run.
module address_hotspot_profile_table_unit
    import ahpt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ahpt_sample_if.sink           i_sample,
    ahpt_result_if.source         o_result,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    function automatic logic [OC_BITS-1:0] clamp_outcome(input logic [7:0] code,
                                                         input logic [2:0] fb);
        logic [7:0] fb_w;
        fb_w = 8'(fb);
        if (code < OC_LIMIT) begin
            return code[OC_BITS-1:0];
        end else if (fb_w < OC_LIMIT) begin
            return OC_BITS'(fb);
        end else begin
            return OC_BITS'(OUTCOME_KINDS - 1);
        end
    endfunction

    t_state               r_state, n_state;
    logic [31:0]          r_addr;
    logic [31:0]          r_cyc;
    logic [OC_BITS-1:0]   r_oc;
    logic [SLOT_BITS-1:0] r_probe;
    logic [SLOT_BITS-1:0] r_cnt;

    t_status              r_res_status;
    logic [SLOT_BITS-1:0] r_res_slot;
    t_slot_row            r_res_row;
    t_lane                r_res_lane;

    logic                 r_out_valid;
    t_status              r_out_status;
    logic [7:0]           r_out_slot;
    t_slot_row            r_out_row;
    t_lane                r_out_lane;
    t_totals              r_out_tot;

    logic [2:0]           w_fallback;
    logic [31:0]          w_prod;
    logic                 w_accept;
    logic                 w_hit;
    logic                 w_empty;
    logic                 w_last;
    logic                 w_found;
    logic                 w_ovf;
    logic                 w_step;
    logic                 w_load_out;
    t_slot_row            w_new_row;
    t_lane                w_new_lane;
    t_store_req           w_req;
    t_store_rsp           w_rsp;
    t_tot_upd             w_upd;
    t_totals              w_tot;

    ahpt_cfg_apb u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_fallback (w_fallback)
    );

    ahpt_slot_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    ahpt_totals u_totals (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (w_upd),
        .o_tot   (w_tot)
    );

    assign i_sample.ready = (r_state == ST_IDLE);
    assign w_accept       = i_sample.valid && i_sample.ready;
    assign w_prod         = i_sample.sample_address * HASH_MULT;

    assign w_empty = !w_rsp.valid;
    assign w_hit   = w_rsp.valid && (w_rsp.row.address == r_addr);
    assign w_last  = (r_cnt == '1);

    always_comb begin
        w_new_row.address   = r_addr;
        w_new_row.samples   = w_rsp.row.samples + 32'd1;
        w_new_row.cycle_sum = w_rsp.row.cycle_sum + {32'd0, r_cyc};
        w_new_row.cycle_max = (r_cyc > w_rsp.row.cycle_max) ? r_cyc : w_rsp.row.cycle_max;
        w_new_lane.samples  = w_rsp.lane.samples + 32'd1;
        w_new_lane.cycles   = w_rsp.lane.cycles + {32'd0, r_cyc};
    end

    always_comb begin
        n_state      = r_state;
        w_found      = 1'b0;
        w_ovf        = 1'b0;
        w_step       = 1'b0;
        w_load_out   = 1'b0;
        w_req        = '0;
        w_req.rd_idx = r_probe;
        w_req.rd_oc  = r_oc;
        w_req.wr_idx = r_probe;
        w_req.wr_oc  = r_oc;
        w_req.wr_new = w_empty;
        w_req.wr_row = w_new_row;
        w_req.wr_lane = w_new_lane;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                w_req.rd_en = 1'b1;
                n_state     = ST_CHECK;
            end
            ST_CHECK: begin
                if (w_hit || w_empty) begin
                    w_req.wr_en = 1'b1;
                    w_found     = 1'b1;
                    n_state     = ST_OUT;
                end else if (w_last) begin
                    w_ovf   = 1'b1;
                    n_state = ST_OUT;
                end else begin
                    w_step  = 1'b1;
                    n_state = ST_READ;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || o_result.ready) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_upd.sample   = w_accept;
        w_upd.cycles   = i_sample.sample_cycles;
        w_upd.oc       = clamp_outcome(i_sample.outcome_code, w_fallback);
        w_upd.insert   = w_found && w_empty;
        w_upd.overflow = w_ovf;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_addr  <= i_sample.sample_address;
            r_cyc   <= i_sample.sample_cycles;
            r_oc    <= clamp_outcome(i_sample.outcome_code, w_fallback);
            r_probe <= w_prod[SLOT_BITS-1:0];
            r_cnt   <= '0;
        end else if (w_step) begin
            r_probe <= r_probe + SLOT_BITS'(1);
            r_cnt   <= r_cnt + SLOT_BITS'(1);
        end

        if (w_found) begin
            r_res_status <= w_empty ? STATUS_NEW : STATUS_HIT;
            r_res_slot   <= r_probe;
            r_res_row    <= w_new_row;
            r_res_lane   <= w_new_lane;
        end else if (w_ovf) begin
            r_res_status <= STATUS_OVERFLOW;
            r_res_slot   <= '0;
            r_res_row    <= '0;
            r_res_lane   <= '0;
        end

        if (w_load_out) begin
            r_out_status <= r_res_status;
            r_out_slot   <= 8'(r_res_slot);
            r_out_row    <= r_res_row;
            r_out_lane   <= r_res_lane;
            r_out_tot    <= w_tot;
        end
    end

    assign o_result.valid                 = r_out_valid;
    assign o_result.status                = r_out_status;
    assign o_result.slot_index            = r_out_slot;
    assign o_result.entry_samples         = r_out_row.samples;
    assign o_result.entry_cycle_sum       = r_out_row.cycle_sum;
    assign o_result.entry_cycle_max       = r_out_row.cycle_max;
    assign o_result.entry_outcome_samples = r_out_lane.samples;
    assign o_result.entry_outcome_cycles  = r_out_lane.cycles;
    assign o_result.global_samples        = r_out_tot.samples;
    assign o_result.global_cycle_sum      = r_out_tot.cycle_sum;
    assign o_result.global_cycle_max      = r_out_tot.cycle_max;
    assign o_result.distinct_addresses    = r_out_tot.occupied;
    assign o_result.overflow_samples      = r_out_tot.overflow;

endmodule

// ===== hw/rtl/ahpt_checker.sv =====
// Port-level checker for the hotspot profile table, bound to the top level.
// Depends on ahpt_pkg and address_hotspot_profile_table_unit_macros.svh.
`include "address_hotspot_profile_table_unit_macros.svh"

module ahpt_checker
    import ahpt_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_status,
    input logic [7:0]  i_slot_index,
    input logic [31:0] i_entry_samples,
    input logic [63:0] i_entry_cycle_sum,
    input logic [31:0] i_global_samples
);

    logic [31:0] r_last_gs;
    logic        w_beat;

    assign w_beat = i_out_valid && i_out_ready;

    // each result beat accounts for exactly one more sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_gs <= 32'd0;
        end else if (w_beat) begin
            r_last_gs <= i_global_samples;
        end
    end

    `AHPT_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_status) && $stable(i_global_samples) && $stable(i_entry_cycle_sum))
    `AHPT_ASSERT_IMP(a_sample_seq, i_clk, i_rst_n, w_beat,
        i_global_samples == r_last_gs + 32'd1)
    `AHPT_ASSERT_IMP(a_ovf_zero, i_clk, i_rst_n, i_out_valid && (i_status == STATUS_OVERFLOW),
        i_slot_index == 8'd0 && i_entry_samples == 32'd0 && i_entry_cycle_sum == 64'd0)
    `AHPT_ASSERT_IMP(a_new_first, i_clk, i_rst_n, i_out_valid && (i_status == STATUS_NEW),
        i_entry_samples == 32'd1)

endmodule

bind address_hotspot_profile_table_unit ahpt_checker u_ahpt_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_result.valid),
    .i_out_ready       (o_result.ready),
    .i_status          (o_result.status),
    .i_slot_index      (o_result.slot_index),
    .i_entry_samples   (o_result.entry_samples),
    .i_entry_cycle_sum (o_result.entry_cycle_sum),
    .i_global_samples  (o_result.global_samples)
);
